// ===== rtl/keyed_record_table_core_defines.svh =====
// assertion helpers for the table core rtl
`ifndef KEYED_RECORD_TABLE_CORE_DEFINES_SVH
`define KEYED_RECORD_TABLE_CORE_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define KRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/krt_pkg.sv =====
`timescale 1ns / 1ps
package krt_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int MODE_W   = 2;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 16;
  localparam int STATUS_W = 3;
  localparam int ENTRY_W  = 8;

  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEL    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

  // operation broadcast to every cell while an item runs down the row
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [CNT_W-1:0]  count;
  } ctl_t;

  // token handed from cell to cell, one hop per cycle
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [VAL_W-1:0] value;
  } tok_t;

endpackage

// ===== rtl/keyed_record_table_core.sv =====
`timescale 1ns / 1ps
// keyed record table: up to TABLE_DEPTH unique keys with one value each.
// input channel (in_valid/in_ready) carries mode, key and value_in; mode 0 adds
// a key at the end, 1 searches, 2 deletes and closes the gap keeping order.
// output channel (out_valid/out_ready) returns one item per input: status,
// value_out (search hit only, else zero) and entry_count after the operation.
// the entries live in a row of TABLE_DEPTH cells; an operation token walks the
// row one cell per cycle, from the start register through the token register of
// each cell to the output register, and one item is in flight at a time;
// in_ready comes back as the result enters the output register, so no new item
// is taken before the last one has left the row.
// a finished item waits in the output register; one more can be parked in a
// hold register, so a new item is taken while the output is stalled; input
// stops while an item is in flight or the hold register is full.
// reset empties the table (entry count zero) and drops any item in flight or
// waiting; no clearing pass is needed.
module keyed_record_table_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [krt_pkg::MODE_W-1:0]       mode,
  input  logic signed [krt_pkg::KEY_W-1:0] key,
  input  logic [krt_pkg::VAL_W-1:0]        value_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [krt_pkg::STATUS_W-1:0]     status,
  output logic [krt_pkg::VAL_W-1:0]        value_out,
  output logic [krt_pkg::ENTRY_W-1:0]      entry_count
);
  import krt_pkg::*;

  `include "keyed_record_table_core_defines.svh"

  logic                busy;
  logic                start;
  logic [MODE_W-1:0]   mode_reg;
  logic [KEY_W-1:0]    key_reg;
  logic [VAL_W-1:0]    value_reg;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic                hold_valid;
  logic [STATUS_W-1:0] hold_status;
  logic [VAL_W-1:0]    hold_value;
  logic [CNT_W-1:0]    hold_count;
  logic [CNT_W-1:0]    out_count;
  logic [STATUS_W-1:0] res_status;
  logic [VAL_W-1:0]    res_value;
  logic                accept;
  logic                done;
  ctl_t                ctl;
  tok_t                tok [TABLE_DEPTH+1];
  logic [KEY_W-1:0]    cell_key   [TABLE_DEPTH];
  logic [VAL_W-1:0]    cell_value [TABLE_DEPTH];

  assign in_ready = !busy && !hold_valid;
  assign accept   = in_valid && in_ready;
  assign done     = tok[TABLE_DEPTH].valid;

  assign ctl.mode  = mode_reg;
  assign ctl.key   = key_reg;
  assign ctl.value = value_reg;
  assign ctl.count = count;

  assign tok[0].valid = start;
  assign tok[0].found = 1'b0;
  assign tok[0].value = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic [KEY_W-1:0] nbr_key;
    logic [VAL_W-1:0] nbr_value;
    if (g == TABLE_DEPTH - 1) begin : g_last
      assign nbr_key   = '0;
      assign nbr_value = '0;
    end else begin : g_mid
      assign nbr_key   = cell_key[g+1];
      assign nbr_value = cell_value[g+1];
    end
    krt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .cell_index (IDX_W'(g)),
      .tok_in     (tok[g]),
      .nbr_key    (nbr_key),
      .nbr_value  (nbr_value),
      .tok_out    (tok[g+1]),
      .cell_key   (cell_key[g]),
      .cell_value (cell_value[g])
    );
  end

  // outcome once the token leaves the last cell
  always_comb begin
    res_status = ST_MISSING;
    res_value  = '0;
    count_next = count;
    unique case (mode_reg)
      MODE_ADD: begin
        if (count == CNT_W'(TABLE_DEPTH)) begin
          res_status = ST_FULL;
        end else if (tok[TABLE_DEPTH].found) begin
          res_status = ST_DUP;
        end else begin
          res_status = ST_DONE;
          count_next = count + CNT_W'(1);
        end
      end
      MODE_SEARCH: begin
        if (count == '0) begin
          res_status = ST_EMPTY;
        end else if (tok[TABLE_DEPTH].found) begin
          res_status = ST_DONE;
          res_value  = tok[TABLE_DEPTH].value;
        end
      end
      MODE_DEL: begin
        if (count == '0) begin
          res_status = ST_EMPTY;
        end else if (tok[TABLE_DEPTH].found) begin
          res_status = ST_DONE;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        res_status = ST_MISSING;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      start <= 1'b0;
      count <= '0;
    end else begin
      start <= accept;
      if (accept) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      if (done) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_reg  <= mode;
      key_reg   <= key;
      value_reg <= value_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (done) begin
      if (!out_valid || out_ready) begin
        out_valid <= 1'b1;
      end else begin
        hold_valid <= 1'b1;
      end
    end else if (out_valid && out_ready) begin
      out_valid  <= hold_valid;
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      if (!out_valid || out_ready) begin
        status    <= res_status;
        value_out <= res_value;
        out_count <= count_next;
      end else begin
        hold_status <= res_status;
        hold_value  <= res_value;
        hold_count  <= count_next;
      end
    end else if (out_valid && out_ready && hold_valid) begin
      status    <= hold_status;
      value_out <= hold_value;
      out_count <= hold_count;
    end
  end

  assign entry_count = ENTRY_W'(out_count);

  `KRT_ASSERT_NOW(a_count_range, 1'b1, count <= CNT_W'(TABLE_DEPTH),
    "entry count above table depth")
  `KRT_ASSERT_NOW(a_hold_behind_out, hold_valid, out_valid,
    "held item without an item in the output register")
  `KRT_ASSERT_NEXT(a_count_quiet, !done, count == $past(count),
    "entry count changed while no item finished")
  `KRT_ASSERT_NEXT(a_del_step, done && mode_reg == MODE_DEL && tok[TABLE_DEPTH].found,
    count == $past(count) - CNT_W'(1), "delete hit did not drop the entry count")

endmodule

// ===== rtl/krt_cell.sv =====
`timescale 1ns / 1ps
module krt_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  krt_pkg::ctl_t               ctl,
  input  logic [krt_pkg::IDX_W-1:0]   cell_index,
  input  krt_pkg::tok_t               tok_in,
  input  logic [krt_pkg::KEY_W-1:0]   nbr_key,
  input  logic [krt_pkg::VAL_W-1:0]   nbr_value,
  output krt_pkg::tok_t               tok_out,
  output logic [krt_pkg::KEY_W-1:0]   cell_key,
  output logic [krt_pkg::VAL_W-1:0]   cell_value
);
  import krt_pkg::*;

  logic [KEY_W-1:0] entry_key;
  logic [VAL_W-1:0] entry_value;
  logic             live;
  logic             hit;
  logic             shift;
  logic             write;

  assign live  = CNT_W'(cell_index) < ctl.count;
  assign hit   = tok_in.valid && live && !tok_in.found && (entry_key == ctl.key);
  // delete: the matching cell and every later one pull from the right neighbor,
  // which the token has not reached yet
  assign shift = tok_in.valid && (ctl.mode == MODE_DEL) && (tok_in.found || hit);
  // add lands in the first free slot once all live entries missed
  assign write = tok_in.valid && (ctl.mode == MODE_ADD) && !tok_in.found &&
                 (CNT_W'(cell_index) == ctl.count);

  always_ff @(posedge clk) begin
    if (shift) begin
      entry_key   <= nbr_key;
      entry_value <= nbr_value;
    end else if (write) begin
      entry_key   <= ctl.key;
      entry_value <= ctl.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.found <= tok_in.found || hit;
    tok_out.value <= hit ? entry_value : tok_in.value;
  end

  assign cell_key   = entry_key;
  assign cell_value = entry_value;

endmodule

// ===== sim/keyed_record_table_core_test.sv =====
`timescale 1ns / 1ps
module keyed_record_table_core_test;
  import krt_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
  localparam int IDLE_LIMIT   = 5000;
  localparam int LONG_HOLD    = 600;
  localparam int DRAIN_CYCLES = 2 * (TABLE_DEPTH + 1);
  localparam int PHASE_ITEMS  = 360;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    value;
    logic [ENTRY_W-1:0]  count;
  } reply_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic              fixed;
    reply_t            reply;
  } dir_row_t;

  localparam reply_t NO_REPLY = '0;

  // rows with fixed set carry their own expected reply, the rest use the shadow table
  localparam dir_row_t DIRECTED_ROWS [24] = '{
    '{MODE_SEARCH, 32'h0000_0000, 16'h0000, 1'b1, '{ST_EMPTY,   16'h0000, 8'd0}},
    '{MODE_DEL,    32'h8000_0000, 16'h0000, 1'b1, '{ST_EMPTY,   16'h0000, 8'd0}},
    '{MODE_NONE,   32'h7fff_ffff, 16'hffff, 1'b1, '{ST_MISSING, 16'h0000, 8'd0}},
    '{MODE_ADD,    32'h8000_0000, 16'h0000, 1'b1, '{ST_DONE,    16'h0000, 8'd1}},
    '{MODE_ADD,    32'h7fff_ffff, 16'hffff, 1'b1, '{ST_DONE,    16'h0000, 8'd2}},
    '{MODE_ADD,    32'h8000_0000, 16'h1234, 1'b1, '{ST_DUP,     16'h0000, 8'd2}},
    '{MODE_ADD,    32'h0000_0000, 16'h0001, 1'b1, '{ST_DONE,    16'h0000, 8'd3}},
    '{MODE_ADD,    32'hffff_ffff, 16'h8000, 1'b1, '{ST_DONE,    16'h0000, 8'd4}},
    '{MODE_SEARCH, 32'h7fff_ffff, 16'h0000, 1'b1, '{ST_DONE,    16'hffff, 8'd4}},
    '{MODE_SEARCH, 32'h8000_0000, 16'hffff, 1'b1, '{ST_DONE,    16'h0000, 8'd4}},
    '{MODE_SEARCH, 32'h0000_0001, 16'h0000, 1'b1, '{ST_MISSING, 16'h0000, 8'd4}},
    '{MODE_DEL,    32'h8000_0001, 16'h0000, 1'b1, '{ST_MISSING, 16'h0000, 8'd4}},
    '{MODE_NONE,   32'h0000_0000, 16'hffff, 1'b1, '{ST_MISSING, 16'h0000, 8'd4}},
    '{MODE_DEL,    32'h8000_0000, 16'h0000, 1'b1, '{ST_DONE,    16'h0000, 8'd3}},
    '{MODE_SEARCH, 32'hffff_ffff, 16'h0000, 1'b1, '{ST_DONE,    16'h8000, 8'd3}},
    '{MODE_SEARCH, 32'h8000_0000, 16'h0000, 1'b1, '{ST_MISSING, 16'h0000, 8'd3}},
    '{MODE_DEL,    32'hffff_ffff, 16'h0000, 1'b1, '{ST_DONE,    16'h0000, 8'd2}},
    '{MODE_ADD,    32'h8000_0000, 16'haaaa, 1'b0, NO_REPLY},
    '{MODE_DEL,    32'h0000_0000, 16'h0000, 1'b0, NO_REPLY},
    '{MODE_SEARCH, 32'h8000_0000, 16'h0000, 1'b0, NO_REPLY},
    '{MODE_SEARCH, 32'h7fff_ffff, 16'h5555, 1'b0, NO_REPLY},
    '{MODE_DEL,    32'h7fff_ffff, 16'h0000, 1'b0, NO_REPLY},
    '{MODE_DEL,    32'h8000_0000, 16'h0000, 1'b0, NO_REPLY},
    '{MODE_SEARCH, 32'h8000_0000, 16'h0000, 1'b1, '{ST_EMPTY,   16'h0000, 8'd0}}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [MODE_W-1:0]   mode = MODE_ADD;
  logic [KEY_W-1:0]    key = '0;
  logic [VAL_W-1:0]    value_in = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [VAL_W-1:0]    value_out;
  logic [ENTRY_W-1:0]  entry_count;

  keyed_record_table_core dut (.*);

  // shadow copy of the table
  logic [KEY_W-1:0] shadow_keys [TABLE_DEPTH];
  logic [VAL_W-1:0] shadow_vals [TABLE_DEPTH];
  int               shadow_fill = 0;
  reply_t           pending_replies [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int err_count = 0;
  int items_sent = 0;
  int full_visits = 0;
  int status_tally [5] = '{0, 0, 0, 0, 0};
  bit filling = 1'b1;
  int boundary_hits = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic reply_t apply_to_shadow(input logic [MODE_W-1:0] m,
                                             input logic [KEY_W-1:0] k,
                                             input logic [VAL_W-1:0] v);
    reply_t r;
    int pos;
    int i;
    r.status = ST_MISSING;
    r.value = '0;
    pos = shadow_fill;
    for (i = shadow_fill - 1; i >= 0; i--) begin
      if (shadow_keys[i] == k) pos = i;
    end
    case (m)
      MODE_ADD: begin
        if (shadow_fill >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else if (pos < shadow_fill) begin
          r.status = ST_DUP;
        end else begin
          shadow_keys[shadow_fill] = k;
          shadow_vals[shadow_fill] = v;
          shadow_fill++;
          r.status = ST_DONE;
        end
      end
      MODE_SEARCH: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else if (pos < shadow_fill) begin
          r.status = ST_DONE;
          r.value = shadow_vals[pos];
        end
      end
      MODE_DEL: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else if (pos < shadow_fill) begin
          // close the gap, later entries keep their order
          for (i = pos; i < shadow_fill - 1; i++) begin
            shadow_keys[i] = shadow_keys[i + 1];
            shadow_vals[i] = shadow_vals[i + 1];
          end
          shadow_fill--;
          r.status = ST_DONE;
        end
      end
      default: ;
    endcase
    r.count = shadow_fill[ENTRY_W-1:0];
    return r;
  endfunction

  // caller must follow every accept in the same step with another item or a lowered valid
  task automatic offer_item(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k,
                            input logic [VAL_W-1:0] v, input bit use_fixed,
                            input reply_t fixed_reply);
    reply_t predicted;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    key <= k;
    value_in <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_to_shadow(m, k, v);
    pending_replies.push_back(use_fixed ? fixed_reply : predicted);
    items_sent++;
  endtask

  task automatic offer_random_op();
    logic [MODE_W-1:0] m;
    logic [KEY_W-1:0]  k;
    logic [VAL_W-1:0]  v;
    int r;
    r = $urandom_range(99);
    if (r < 3) m = MODE_NONE;
    else if (r < (filling ? 73 : 18)) m = MODE_ADD;
    else if (r < (filling ? 88 : 43)) m = MODE_SEARCH;
    else m = MODE_DEL;

    r = $urandom_range(99);
    if (r < 12) begin
      case ($urandom_range(3))
        0: k = 32'h8000_0000;
        1: k = 32'h7fff_ffff;
        2: k = 32'h0000_0000;
        default: k = 32'hffff_ffff;
      endcase
    end else if (shadow_fill > 0 && r < ((m == MODE_ADD) ? 37 : 82)) begin
      // existing key: duplicates on add, hits on search and delete
      k = shadow_keys[$urandom_range(shadow_fill - 1)];
    end else begin
      k = $urandom();
    end

    r = $urandom_range(19);
    v = (r == 0) ? 16'h0000 : (r == 1) ? 16'hffff : 16'($urandom_range(16'hffff));

    offer_item(m, k, v, 1'b0, NO_REPLY);

    // swing between filling to the top and draining to empty
    if (filling && shadow_fill == TABLE_DEPTH) boundary_hits++;
    if (!filling && shadow_fill == 0) boundary_hits++;
    if (boundary_hits >= 6) begin
      if (filling) full_visits++;
      filling = !filling;
      boundary_hits = 0;
    end
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // result side: stalls, long hold-off and checking
  initial begin
    int hold_left;
    int holds_seen;
    reply_t want;
    hold_left = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d value %h count %0d",
                   $time, status, value_out, entry_count);
          err_count++;
        end else begin
          want = pending_replies.pop_front();
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            err_count++;
          end
          if (value_out !== want.value) begin
            $display("%0t: value_out expected %h actual %h", $time, want.value, value_out);
            err_count++;
          end
          if (entry_count !== want.count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                     entry_count);
            err_count++;
          end
        end
        if (status < 5) status_tally[status]++;
      end
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no item moved for %0d cycles, %0d results outstanding", $time, quiet,
             pending_replies.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    dir_row_t row;
    int p;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      offer_item(row.mode, row.key, row.value, row.fixed, row.reply);
    end
    pause_until_drained();

    // output held off while input keeps coming, so the block backs up
    hold_requests++;
    repeat (24) offer_random_op();
    pause_until_drained();

    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      repeat (PHASE_ITEMS) offer_random_op();
      pause_until_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_replies.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_replies.size());
      err_count++;
    end

    $display("run covered %0d items, table filled to the top %0d times", items_sent,
             full_visits);
    $display("results: %0d done, %0d full, %0d duplicate, %0d missing, %0d empty",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4]);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
